// ===== hw/rtl/compacting_list_buffer_unit_assert.svh =====
// Assertion macros for the compacting list buffer.
// Used by the top level only; needs nothing else.
`ifndef COMPACTING_LIST_BUFFER_UNIT_ASSERT_SVH
`define COMPACTING_LIST_BUFFER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define CLBU_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define CLBU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/clbu_pkg.sv =====
// Shared types and fixed port widths for the compacting list buffer.
// No dependencies.
package clbu_pkg;

  localparam int OP_W      = 2;
  localparam int IDX_W     = 6;
  localparam int VAL_W     = 32;
  localparam int CNT_OUT_W = 7;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND     = 2'd0,
    OP_REMOVE_AT  = 2'd1,
    OP_REMOVE_VAL = 2'd2,
    OP_READ       = 2'd3
  } op_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } state_t;

  // Row-wide commands from the sequencer to the cells.
  typedef struct packed {
    logic append;
    logic shift;
  } cell_ctl_t;

endpackage

// ===== hw/rtl/clbu_cell.sv =====
// One list entry of the cell row: holds a word, loads an appended word,
// takes its upper neighbour's word on a shift and flags a match. Needs no package.
module clbu_cell #(
  parameter int WORD_BITS = 32
) (
  input  logic                 clk,
  input  logic                 load,
  input  logic                 shift,
  input  logic [WORD_BITS-1:0] load_word,
  input  logic [WORD_BITS-1:0] upper_word,
  input  logic [WORD_BITS-1:0] match_word,
  output logic [WORD_BITS-1:0] word,
  output logic                 hit
);

  always_ff @(posedge clk) begin
    if (load) begin
      word <= load_word;
    end else if (shift) begin
      word <= upper_word;
    end
  end

  assign hit = (word == match_word);

endmodule

// ===== hw/rtl/clbu_ctrl.sv =====
// Sequencer of the compacting list buffer: entry count, scan pointer,
// result strobe. Uses clbu_pkg.
module clbu_ctrl #(
  parameter int DEPTH = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [clbu_pkg::OP_W-1:0] op,
  input  logic [clbu_pkg::IDX_W-1:0] index,
  input  logic                      hit,
  output clbu_pkg::cell_ctl_t       ctl,
  output logic [$clog2(DEPTH+1)-1:0] ptr,
  output logic [$clog2(DEPTH+1)-1:0] count,
  output logic                      rd_ok,
  output logic                      busy,
  output logic                      done,
  output logic                      ok
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > clbu_pkg::IDX_W) ? CNT_W : clbu_pkg::IDX_W;

  clbu_pkg::state_t state, state_next;
  logic [CNT_W-1:0] count_next;
  logic [CNT_W-1:0] wr, wr_next;
  logic             removed, removed_next;
  logic             done_next, ok_next;
  logic [CMP_W-1:0] idx_ext, count_ext;
  logic             idx_in_range;

  assign idx_ext      = CMP_W'(index);
  assign count_ext    = CMP_W'(count);
  assign idx_in_range = (idx_ext < count_ext);
  assign busy         = (state != clbu_pkg::ST_IDLE);
  // Shift base: the request's index when idle, the scan pointer otherwise.
  assign ptr          = busy ? wr : idx_ext[CNT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= clbu_pkg::ST_IDLE;
      count   <= '0;
      wr      <= '0;
      removed <= 1'b0;
      done    <= 1'b0;
      ok      <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      wr      <= wr_next;
      removed <= removed_next;
      done    <= done_next;
      ok      <= ok_next;
    end
  end

  always_comb begin
    state_next   = state;
    count_next   = count;
    wr_next      = wr;
    removed_next = removed;
    done_next    = 1'b0;
    ok_next      = 1'b0;
    rd_ok        = 1'b0;
    ctl          = '0;
    case (state)
      clbu_pkg::ST_IDLE: begin
        if (start) begin
          case (clbu_pkg::op_t'(op))
            clbu_pkg::OP_APPEND: begin
              done_next = 1'b1;
              if (count < CNT_W'(DEPTH)) begin
                ctl.append = 1'b1;
                count_next = count + CNT_W'(1);
                ok_next    = 1'b1;
              end
            end
            clbu_pkg::OP_REMOVE_AT: begin
              done_next = 1'b1;
              if (idx_in_range) begin
                ctl.shift  = 1'b1;
                count_next = count - CNT_W'(1);
                ok_next    = 1'b1;
              end
            end
            clbu_pkg::OP_REMOVE_VAL: begin
              state_next   = clbu_pkg::ST_SCAN;
              wr_next      = '0;
              removed_next = 1'b0;
            end
            clbu_pkg::OP_READ: begin
              done_next = 1'b1;
              if (idx_in_range) begin
                rd_ok   = 1'b1;
                ok_next = 1'b1;
              end
            end
            default: begin
              done_next = 1'b1;
            end
          endcase
        end
      end
      clbu_pkg::ST_SCAN: begin
        // Each step either drops the entry at the pointer or advances past it, until the pointer reaches the count.
        if (wr == count) begin
          done_next  = 1'b1;
          ok_next    = removed;
          state_next = clbu_pkg::ST_IDLE;
        end else if (hit) begin
          ctl.shift    = 1'b1;
          count_next   = count - CNT_W'(1);
          removed_next = 1'b1;
        end else begin
          wr_next = wr + CNT_W'(1);
        end
      end
      default: begin
        state_next = clbu_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/compacting_list_buffer_unit.sv =====
// Compacting list buffer: a row of DEPTH cells kept densely packed.
// Append, remove-at and read: result strobe in the cycle after the accepting
// edge; a new request may be accepted in every cycle for these.
// Remove-value: one scan step per entry held, then a closing step that raises
// the result strobe; busy is high meanwhile.
// Reset clears the entry count and sequencer; stored words are not cleared.
module compacting_list_buffer_unit #(
  parameter int DEPTH     = 64,
  parameter int WORD_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [clbu_pkg::OP_W-1:0]      op,
  input  logic [clbu_pkg::IDX_W-1:0]     index,
  input  logic [clbu_pkg::VAL_W-1:0]     value,
  output logic                           busy,
  output logic                           done,
  output logic [clbu_pkg::VAL_W-1:0]     read_value,
  output logic                           ok,
  output logic [clbu_pkg::CNT_OUT_W-1:0] entry_count
);

  `include "compacting_list_buffer_unit_assert.svh"

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int AW    = $clog2(DEPTH);
  localparam int CMP_W = (CNT_W > clbu_pkg::IDX_W) ? CNT_W : clbu_pkg::IDX_W;

  clbu_pkg::cell_ctl_t   ctl;
  logic [CNT_W-1:0]      ptr;
  logic [CNT_W-1:0]      count;
  logic                  rd_ok;
  logic                  hit;
  logic                  accept;
  logic [WORD_BITS-1:0]  word_in;
  logic [WORD_BITS-1:0]  match_word;
  logic [WORD_BITS-1:0]  words [DEPTH];
  logic [DEPTH-1:0]      hits;
  logic [CMP_W-1:0]      idx_ext;
  logic [WORD_BITS-1:0]  read_word;

  assign accept  = start && !busy;
  assign word_in = WORD_BITS'(value);
  assign idx_ext = CMP_W'(index);

  // Hold the match value for the whole scan.
  always_ff @(posedge clk) begin
    if (accept) begin
      match_word <= word_in;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WORD_BITS-1:0] upper;
    if (i == DEPTH - 1) begin : g_top
      assign upper = words[i];
    end else begin : g_mid
      assign upper = words[i+1];
    end
    clbu_cell #(
      .WORD_BITS (WORD_BITS)
    ) u_cell (
      .clk        (clk),
      .load       (ctl.append && (count == CNT_W'(i))),
      .shift      (ctl.shift && (CNT_W'(i) >= ptr)),
      .load_word  (word_in),
      .upper_word (upper),
      .match_word (match_word),
      .word       (words[i]),
      .hit        (hits[i])
    );
  end

  assign hit = (ptr < CNT_W'(DEPTH)) ? hits[ptr[AW-1:0]] : 1'b0;

  clbu_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .op    (op),
    .index (index),
    .hit   (hit),
    .ctl   (ctl),
    .ptr   (ptr),
    .count (count),
    .rd_ok (rd_ok),
    .busy  (busy),
    .done  (done),
    .ok    (ok)
  );

  // Zero unless this cycle launches a successful read.
  always_ff @(posedge clk) begin
    read_word <= rd_ok ? words[idx_ext[AW-1:0]] : '0;
  end

  assign read_value  = clbu_pkg::VAL_W'(read_word);
  assign entry_count = clbu_pkg::CNT_OUT_W'(count);

  `CLBU_ASSERT_NEXT(a_accept_answers, clk, rst, accept, done || busy,
    "accepted request neither answered nor scanning")
  `CLBU_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, count <= CNT_W'(DEPTH),
    "entry count beyond capacity")
  `CLBU_ASSERT_NOW(a_scan_ptr, clk, rst, busy, ptr <= count,
    "scan pointer past the end of the list")
  `CLBU_ASSERT_NOW(a_one_cmd, clk, rst, ctl.append, !ctl.shift,
    "append and shift in the same cycle")

endmodule

// ===== sim/list_buffer_monitor.sv =====
// Watches the request and reply channels of the compacting list buffer, keeps a
// shadow copy of the list and checks every reply beat against it.
// Depends on clbu_pkg for the operation codes.
module list_buffer_monitor #(
  parameter int DEPTH = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [clbu_pkg::OP_W-1:0]      op,
  input  logic [clbu_pkg::IDX_W-1:0]     index,
  input  logic [clbu_pkg::VAL_W-1:0]     value,
  input  logic                           busy,
  input  logic                           done,
  input  logic [clbu_pkg::VAL_W-1:0]     read_value,
  input  logic                           ok,
  input  logic [clbu_pkg::CNT_OUT_W-1:0] entry_count,
  output int                             mismatches,
  output int                             outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import clbu_pkg::*;

  typedef struct {
    logic [VAL_W-1:0]     read_value;
    logic                 ok;
    logic [CNT_OUT_W-1:0] entry_count;
  } reply_t;

  logic [VAL_W-1:0] shadow_list[$];
  reply_t           awaited_replies[$];

  // Apply one request to the shadow list and return the reply it should give.
  function automatic reply_t apply_request(op_t code, logic [IDX_W-1:0] pos,
                                           logic [VAL_W-1:0] word);
    reply_t           r;
    logic [VAL_W-1:0] kept[$];
    r.read_value = '0;
    r.ok         = 1'b0;
    case (code)
      OP_APPEND: begin
        if (shadow_list.size() < DEPTH) begin
          shadow_list.push_back(word);
          r.ok = 1'b1;
        end
      end
      OP_REMOVE_AT: begin
        if (pos < shadow_list.size()) begin
          shadow_list.delete(pos);
          r.ok = 1'b1;
        end
      end
      OP_REMOVE_VAL: begin
        // keep every non-matching word in order; neighbours that match all go
        foreach (shadow_list[k])
          if (shadow_list[k] != word) kept.push_back(shadow_list[k]);
        r.ok = (kept.size() != shadow_list.size());
        shadow_list = kept;
      end
      default: begin
        if (pos < shadow_list.size()) begin
          r.read_value = shadow_list[pos];
          r.ok         = 1'b1;
        end
      end
    endcase
    r.entry_count = CNT_OUT_W'(shadow_list.size());
    return r;
  endfunction

  always @(posedge clk) begin
    reply_t want;
    if (rst) begin
      shadow_list.delete();
      awaited_replies.delete();
    end else begin
      // retire the reply beat first: it can never belong to this edge's request
      if (done) begin
        if (awaited_replies.size() == 0) begin
          $display("%0t: reply with none pending: read_value %h ok %b entry_count %0d",
                   $realtime, read_value, ok, entry_count);
          mismatches++;
        end else begin
          want = awaited_replies.pop_front();
          if (read_value !== want.read_value) begin
            $display("%0t: read_value expected %h got %h", $realtime,
                     want.read_value, read_value);
            mismatches++;
          end
          if (ok !== want.ok) begin
            $display("%0t: ok expected %b got %b", $realtime, want.ok, ok);
            mismatches++;
          end
          if (entry_count !== want.entry_count) begin
            $display("%0t: entry_count expected %0d got %0d", $realtime,
                     want.entry_count, entry_count);
            mismatches++;
          end
        end
      end
      if (start && !busy)
        awaited_replies.push_back(apply_request(op_t'(op), index, value));
    end
    outstanding <= awaited_replies.size();
  end

endmodule

// ===== sim/compacting_list_buffer_unit_test.sv =====
// Top of the compacting list buffer testbench: clock, reset and request stimulus.
// Instantiates the block beside list_buffer_monitor, which does all checking.
// Depends on clbu_pkg, compacting_list_buffer_unit and list_buffer_monitor.
module compacting_list_buffer_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import clbu_pkg::*;

  localparam int DEPTH       = 64;
  localparam int SEGMENTS    = 20;
  localparam int SEG_ITEMS   = 100;
  localparam int DRAIN_LIMIT = 20000;

  typedef enum int {MIX_GROW, MIX_SHRINK, MIX_BALANCED} mix_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 start;
  logic [OP_W-1:0]      op;
  logic [IDX_W-1:0]     index;
  logic [VAL_W-1:0]     value;
  logic                 busy;
  logic                 done;
  logic [VAL_W-1:0]     read_value;
  logic                 ok;
  logic [CNT_OUT_W-1:0] entry_count;

  int mismatches;
  int outstanding;
  int idle_pct;
  int last_count;
  logic [VAL_W-1:0] word_pool[4];

  compacting_list_buffer_unit #(.DEPTH(DEPTH), .WORD_BITS(32)) dut (
    .clk(clk), .rst(rst), .start(start), .op(op), .index(index), .value(value),
    .busy(busy), .done(done), .read_value(read_value), .ok(ok),
    .entry_count(entry_count)
  );

  list_buffer_monitor #(.DEPTH(DEPTH)) monitor (
    .clk(clk), .rst(rst), .start(start), .op(op), .index(index), .value(value),
    .busy(busy), .done(done), .read_value(read_value), .ok(ok),
    .entry_count(entry_count), .mismatches(mismatches), .outstanding(outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end

  // Rough list length for steering indexes; may trail by one request.
  always @(posedge clk) begin
    if (rst) begin
      last_count <= 0;
    end else if (done) begin
      last_count <= int'(entry_count);
    end
  end

  // Offer one request, idling first at random, and hold it until accepted.
  task automatic issue(input op_t code, input logic [IDX_W-1:0] pos,
                       input logic [VAL_W-1:0] word);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    op    <= code;
    index <= pos;
    value <= word;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Hold off until every pending reply has come back.
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic pick_index(output logic [IDX_W-1:0] pos);
    int roll;
    int lo;
    roll = $urandom_range(99);
    lo   = (last_count > 0) ? last_count - 1 : 0;
    if (roll < 70) begin
      pos = IDX_W'((last_count > 63) ? $urandom_range(63) : $urandom_range(last_count));
    end else if (roll < 85) begin
      pos = IDX_W'($urandom_range((lo > 63) ? 63 : lo, 63));
    end else begin
      pos = IDX_W'($urandom_range(63));
    end
  endtask

  task automatic pick_word(output logic [VAL_W-1:0] word);
    // a small pool makes duplicates and remove-value matches common
    if ($urandom_range(99) < 60) begin
      word = word_pool[$urandom_range(3)];
    end else begin
      word = $urandom;
    end
  endtask

  task automatic refresh_pool();
    foreach (word_pool[k]) word_pool[k] = $urandom;
    if ($urandom_range(1)) word_pool[0] = '0;
    if ($urandom_range(1)) word_pool[3] = '1;
  endtask

  task automatic run_segment(input mix_t mix, input int items);
    op_t              code;
    logic [IDX_W-1:0] pos;
    logic [VAL_W-1:0] word;
    int               roll;
    refresh_pool();
    repeat (items) begin
      roll = $urandom_range(99);
      case (mix)
        MIX_GROW:
          code = (roll < 65) ? OP_APPEND : (roll < 75) ? OP_REMOVE_AT :
                 (roll < 83) ? OP_REMOVE_VAL : OP_READ;
        MIX_SHRINK:
          code = (roll < 25) ? OP_APPEND : (roll < 60) ? OP_REMOVE_AT :
                 (roll < 80) ? OP_REMOVE_VAL : OP_READ;
        default:
          code = (roll < 40) ? OP_APPEND : (roll < 60) ? OP_REMOVE_AT :
                 (roll < 72) ? OP_REMOVE_VAL : OP_READ;
      endcase
      pick_index(pos);
      pick_word(word);
      issue(code, pos, word);
    end
  endtask

  initial begin
    int n;
    int idle_steps[3];
    idle_steps = '{0, 53, 17};
    rst      <= 1'b1;
    start    <= 1'b0;
    op       <= '0;
    index    <= '0;
    value    <= '0;
    idle_pct = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty list: every request is refused
    issue(OP_READ, 6'd0, 32'h0);
    issue(OP_REMOVE_AT, 6'd0, 32'h0);
    issue(OP_REMOVE_VAL, 6'd0, 32'h0);
    // a run of equal neighbours, then reads in and past the end
    issue(OP_APPEND, 6'd0, 32'h0000_0000);
    issue(OP_APPEND, 6'd63, 32'hFFFF_FFFF);
    issue(OP_APPEND, 6'd0, 32'hFFFF_FFFF);
    issue(OP_APPEND, 6'd0, 32'hFFFF_FFFF);
    issue(OP_APPEND, 6'd0, 32'hA5A5_A5A5);
    issue(OP_READ, 6'd0, 32'h0);
    issue(OP_READ, 6'd4, 32'h0);
    issue(OP_READ, 6'd5, 32'h0);
    issue(OP_READ, 6'd63, 32'hFFFF_FFFF);
    issue(OP_REMOVE_VAL, 6'd0, 32'hFFFF_FFFF);
    issue(OP_READ, 6'd1, 32'h0);
    issue(OP_REMOVE_AT, 6'd63, 32'h0);
    issue(OP_REMOVE_AT, 6'd2, 32'h0);
    issue(OP_REMOVE_AT, 6'd0, 32'h0);
    issue(OP_REMOVE_VAL, 6'd0, 32'h5A5A_5A5A);
    issue(OP_REMOVE_AT, 6'd0, 32'h0);
    issue(OP_APPEND, 6'd0, 32'h5A5A_5A5A);
    issue(OP_REMOVE_VAL, 6'd0, 32'h5A5A_5A5A);
    drain();

    // fill past capacity, read both ends, then one full-length scan
    refresh_pool();
    for (n = 0; n < DEPTH + 4; n++) issue(OP_APPEND, IDX_W'(n), word_pool[$urandom_range(3)]);
    issue(OP_READ, 6'd63, 32'h0);
    issue(OP_READ, 6'd0, 32'h0);
    issue(OP_REMOVE_VAL, 6'd0, word_pool[0]);
    drain();

    for (n = 0; n < SEGMENTS; n++) begin
      idle_pct = idle_steps[(n / 3) % 3];
      run_segment(mix_t'(n % 3), SEG_ITEMS);
      drain();
    end

    start <= 1'b0;
    n = 0;
    do begin
      @(posedge clk);
      n++;
    end while (outstanding != 0 && n < DRAIN_LIMIT);
    repeat (DEPTH + 4) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
